[sv/event_ring_queue_top_assert.svh]
// Assertion macros shared by the event ring queue RTL.
`ifndef EVENT_RING_QUEUE_TOP_ASSERT_SVH
`define EVENT_RING_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checks that a condition holds in the same cycle as its trigger.
`define ERQ_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Checks that a condition holds in the cycle after its trigger.
`define ERQ_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ERQ_ASSERT_NOW(lbl, pre, post, msg)
`define ERQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

[sv/erq_pkg.sv]
// Types and constants shared by the event ring queue modules.
package erq_pkg;

    localparam int QUEUE_SLOTS_DEF = 64;
    localparam int FILL_W          = 6;
    localparam int CNT_W           = 32;

    typedef enum logic [1:0] {
        ACT_SUBMIT  = 2'd0,
        ACT_POP     = 2'd1,
        ACT_DISCARD = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_GATED = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_READ = 1'b1
    } fsm_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        gate_open;
        logic [7:0]  key_index;
        logic        is_pressed;
        logic [7:0]  strike_velocity;
        logic [31:0] timer_stamp;
        logic        shift_held;
        logic        track_armed;
        logic [7:0]  sensor_mode;
        logic [7:0]  active_track;
        logic [31:0] capture_time_ms;
    } req_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       out_stamp;
        logic [31:0]       out_serial;
        logic [7:0]        out_key;
        logic [2:0]        out_flags;
        logic [7:0]        out_velocity;
        logic [7:0]        out_mode;
        logic [7:0]        out_track;
        logic [31:0]       out_capture_ms;
        logic [FILL_W-1:0] fill_level;
        logic [CNT_W-1:0]  drops_seen;
    } rsp_word_t;

    // One stored event: capture time, timer tick, serial and the packed fields.
    typedef struct packed {
        logic [31:0]      cap_time;
        logic [31:0]      stamp;
        logic [CNT_W-1:0] serial;
        logic [7:0]       key;
        logic [7:0]       velocity;
        logic [7:0]       mode;
        logic [7:0]       track;
        logic [2:0]       flags;
    } mem_word_t;

    localparam int MEM_W = $bits(mem_word_t);

    // Outcome of one action as worked out by the pointer unit.
    typedef struct packed {
        status_t           status;
        logic              wr_en;
        logic              rd_en;
        logic [FILL_W-1:0] fill;
        logic [CNT_W-1:0]  drops;
        logic [CNT_W-1:0]  serial;
    } ptr_info_t;

endpackage

[sv/erq_chan_if.sv]
// Valid/ready channel carrying one word of the given type.
interface erq_chan_if #(
    parameter type word_t = logic
) ();
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/erq_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module erq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/erq_ptr.sv]
// Ring pointers, serial and drop counters, and the per-action decision.
module erq_ptr import erq_pkg::*; #(
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [1:0]                     action,
    input  logic                           gate_open,
    output logic [$clog2(QUEUE_SLOTS)-1:0] wr_addr,
    output logic [$clog2(QUEUE_SLOTS)-1:0] rd_addr,
    output ptr_info_t                      info
);

    localparam int PW = $clog2(QUEUE_SLOTS);
    localparam int DW = PW + 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_SLOTS - 1);

    logic [PW-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        serial_reg, serial_next;
    logic [CNT_W-1:0]        drop_reg, drop_next;
    logic [PW-1:0]           wr_inc, rd_inc;
    logic [CNT_W-1:0]        serial_new;
    logic [DW-1:0]           depth;
    logic [DW+FILL_W-1:0]    fill_ext;

    assign wr_inc     = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_inc     = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    // The serial number skips zero when it wraps.
    assign serial_new = (serial_reg == '1) ? CNT_W'(1) : serial_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        serial_next = serial_reg;
        drop_next   = drop_reg;
        info.status = STAT_OK;
        info.wr_en  = 1'b0;
        info.rd_en  = 1'b0;
        unique case (action)
            ACT_SUBMIT:
            begin
                if (!gate_open)
                begin
                    info.status = STAT_GATED;
                end
                else if (wr_inc == rd_ptr_reg)
                begin
                    info.status = STAT_FULL;
                    drop_next   = drop_reg + 1'b1;
                end
                else
                begin
                    info.wr_en  = 1'b1;
                    serial_next = serial_new;
                    wr_ptr_next = wr_inc;
                end
            end
            ACT_POP:
            begin
                if (rd_ptr_reg == wr_ptr_reg)
                begin
                    info.status = STAT_EMPTY;
                end
                else
                begin
                    info.rd_en  = 1'b1;
                    rd_ptr_next = rd_inc;
                end
            end
            ACT_DISCARD:
            begin
                rd_ptr_next = wr_ptr_reg;
            end
            ACT_CLEAR:
            begin
                wr_ptr_next = '0;
                rd_ptr_next = '0;
                serial_next = '0;
                drop_next   = '0;
            end
            default:
            begin
                info.status = STAT_OK;
            end
        endcase

        if (wr_ptr_next >= rd_ptr_next)
        begin
            depth = DW'(wr_ptr_next) - DW'(rd_ptr_next);
        end
        else
        begin
            depth = DW'(wr_ptr_next) + DW'(QUEUE_SLOTS) - DW'(rd_ptr_next);
        end
        // The reported depth keeps only its low bits on deep rings.
        fill_ext    = {FILL_W'(0), depth};
        info.fill   = fill_ext[FILL_W-1:0];
        info.drops  = drop_next;
        info.serial = serial_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            serial_reg <= '0;
            drop_reg   <= '0;
        end
        else if (step)
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            serial_reg <= serial_next;
            drop_reg   <= drop_next;
        end
    end

    assign wr_addr = wr_ptr_reg;
    assign rd_addr = rd_ptr_reg;

endmodule

[sv/event_ring_queue_top.sv]
// Top level of the event ring queue: RAM, pointer unit, pop sequencer and result register.

// Event ring queue. Each word on req is one action (submit, pop, discard or
// clear) and yields exactly one word on rsp carrying a status, the depth after
// the action and the drop count, plus the event itself for a successful pop.
// The ring holds at most QUEUE_SLOTS-1 events in one RAM of QUEUE_SLOTS
// entries. The block takes one submit, discard, clear or refused action per
// clock as long as results are taken. A pop that finds an event waits in the
// read state for the registered read of the event RAM; no new word is taken
// while it waits. The result register parts the two sides, so a new word is
// taken in the same cycle that the previous result leaves. The RAM is not
// cleared after reset and needs no clearing pass: a pop only ever reads
// entries that a submit has written. A read is always issued after the write
// to the same entry has been registered, so no forwarding path is needed.

`include "event_ring_queue_top_assert.svh"

module event_ring_queue_top import erq_pkg::*; #(
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    erq_chan_if.sink     req,
    erq_chan_if.source   rsp
);

    localparam int AW = $clog2(QUEUE_SLOTS);

    fsm_t             fsm_reg, fsm_next;
    logic             rsp_valid_reg;
    rsp_word_t        rsp_word_reg, rsp_word_next;
    req_word_t        req_word;
    ptr_info_t        info;
    logic             accept;
    logic [AW-1:0]    wr_addr, rd_addr;
    mem_word_t        wr_word, rd_word;
    logic [MEM_W-1:0] ram_rdata;

    assign req_word = req.data;

    // New words are taken only when no pop read is in flight and the result
    // register is free or is being emptied in this cycle.
    assign req.ready = (fsm_reg == FSM_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    erq_ptr #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_ptr (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .action    (req_word.action),
        .gate_open (req_word.gate_open),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .info      (info)
    );

    // Pack the submitted event into one RAM word.
    always_comb
    begin
        wr_word.cap_time   = req_word.capture_time_ms;
        wr_word.stamp      = req_word.timer_stamp;
        wr_word.serial     = info.serial;
        wr_word.key        = req_word.key_index;
        wr_word.velocity   = req_word.strike_velocity;
        wr_word.mode       = req_word.sensor_mode;
        wr_word.track      = req_word.active_track;
        wr_word.flags      = {req_word.track_armed, req_word.shift_held,
                              req_word.is_pressed};
    end

    erq_ram #(
        .WIDTH (MEM_W),
        .DEPTH (QUEUE_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (accept && info.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (accept && info.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    assign rd_word = mem_word_t'(ram_rdata);

    // Pop sequencer: a pop that finds an event waits in FSM_READ for the RAM data.
    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            FSM_IDLE:
            begin
                if (accept && info.rd_en)
                begin
                    fsm_next = FSM_READ;
                end
            end
            FSM_READ:
            begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg <= FSM_IDLE;
        end
        else
        begin
            fsm_reg <= fsm_next;
        end
    end

    // Result word: status, depth and drops are settled when the word is taken;
    // the event fields stay zero unless the RAM read of a pop fills them.
    always_comb
    begin
        rsp_word_next = rsp_word_reg;
        if (accept)
        begin
            rsp_word_next            = '0;
            rsp_word_next.status     = info.status;
            rsp_word_next.fill_level = info.fill;
            rsp_word_next.drops_seen = info.drops;
        end
        else if (fsm_reg == FSM_READ)
        begin
            rsp_word_next.out_stamp      = rd_word.stamp;
            rsp_word_next.out_serial     = rd_word.serial;
            rsp_word_next.out_key        = rd_word.key;
            rsp_word_next.out_flags      = rd_word.flags;
            rsp_word_next.out_velocity   = rd_word.velocity;
            rsp_word_next.out_mode       = rd_word.mode;
            rsp_word_next.out_track      = rd_word.track;
            rsp_word_next.out_capture_ms = rd_word.cap_time;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fsm_reg == FSM_READ)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (accept && !info.rd_en)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_word_reg;

    `ERQ_ASSERT_NOW(a_no_take_in_read, fsm_reg == FSM_READ, !req.ready,
        "word taken during pop read")
    `ERQ_ASSERT_NEXT(a_pop_waits, accept && info.rd_en,
        (fsm_reg == FSM_READ) && !rsp_valid_reg, "pop result shown before RAM data")
    `ERQ_ASSERT_NEXT(a_pop_result, fsm_reg == FSM_READ,
        rsp_valid_reg && (rsp_word_reg.status == STAT_OK) && (rsp_word_reg.out_serial != '0),
        "popped event lacks a valid serial")
    `ERQ_ASSERT_NOW(a_no_event_payload, rsp_valid_reg && (rsp_word_reg.status != STAT_OK),
        (rsp_word_reg.out_serial == '0) && (rsp_word_reg.out_stamp == '0),
        "event fields set on a refused action")

endmodule

[sim/event_queue_checker.sv]
// Checker for the event ring queue: predicts each result word and compares it with the block.
`timescale 1ns / 100ps

module event_queue_checker import erq_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  req_word_t   req_data,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  rsp_word_t   rsp_data,
    output int unsigned mismatches,
    output int unsigned awaiting,
    output int unsigned stored_events,
    output int unsigned full_refusals,
    output int unsigned popped_events,
    output int unsigned empty_pops
);

    localparam int SLOTS = QUEUE_SLOTS_DEF;

    // Shadow copy of the ring and its pointers and counters.
    mem_word_t   ring_copy [SLOTS];
    int unsigned head_idx;
    int unsigned tail_idx;
    logic [31:0] last_serial;
    logic [31:0] drop_tally;
    rsp_word_t   pending_results [$];

    function automatic int unsigned ring_advance(int unsigned p);
        return (p + 1 >= SLOTS) ? 0 : p + 1;
    endfunction

    function automatic int unsigned queued_count();
        if (tail_idx >= head_idx)
            return tail_idx - head_idx;
        return tail_idx + SLOTS - head_idx;
    endfunction

    // Applies one action to the shadow state and returns the word the block must answer.
    function automatic rsp_word_t predict_result(req_word_t w);
        rsp_word_t r;
        mem_word_t e;
        r = '0;
        r.status = STAT_OK;
        case (action_t'(w.action))
            ACT_SUBMIT:
            begin
                if (!w.gate_open)
                    r.status = STAT_GATED;
                else if (ring_advance(tail_idx) == head_idx)
                begin
                    drop_tally = drop_tally + 32'd1;
                    r.status = STAT_FULL;
                    full_refusals++;
                end
                else
                begin
                    last_serial = last_serial + 32'd1;
                    if (last_serial == 32'd0)
                        last_serial = 32'd1;
                    e.cap_time   = w.capture_time_ms;
                    e.stamp      = w.timer_stamp;
                    e.serial     = last_serial;
                    e.key        = w.key_index;
                    e.velocity   = w.strike_velocity;
                    e.mode       = w.sensor_mode;
                    e.track      = w.active_track;
                    e.flags      = {w.track_armed, w.shift_held, w.is_pressed};
                    ring_copy[tail_idx] = e;
                    tail_idx = ring_advance(tail_idx);
                    stored_events++;
                end
            end
            ACT_POP:
            begin
                if (head_idx == tail_idx)
                begin
                    r.status = STAT_EMPTY;
                    empty_pops++;
                end
                else
                begin
                    e = ring_copy[head_idx];
                    r.out_stamp      = e.stamp;
                    r.out_serial     = e.serial;
                    r.out_key        = e.key;
                    r.out_flags      = e.flags;
                    r.out_velocity   = e.velocity;
                    r.out_mode       = e.mode;
                    r.out_track      = e.track;
                    r.out_capture_ms = e.cap_time;
                    head_idx = ring_advance(head_idx);
                    popped_events++;
                end
            end
            ACT_DISCARD:
                head_idx = tail_idx;
            default:
            begin
                head_idx    = 0;
                tail_idx    = 0;
                last_serial = '0;
                drop_tally  = '0;
            end
        endcase
        r.fill_level = FILL_W'(queued_count());
        r.drops_seen = drop_tally;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t want;
        if (!rst_n)
        begin
            head_idx      = 0;
            tail_idx      = 0;
            last_serial   = '0;
            drop_tally    = '0;
            pending_results.delete();
            mismatches    = 0;
            stored_events = 0;
            full_refusals = 0;
            popped_events = 0;
            empty_pops    = 0;
        end
        else
        begin
            // A result leaving now belongs to an earlier action, so check before predicting.
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with no action outstanding: 0x%0h", rsp_data);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, rsp_data.status);
                    check_field("out_stamp", want.out_stamp, rsp_data.out_stamp);
                    check_field("out_serial", want.out_serial, rsp_data.out_serial);
                    check_field("out_key", want.out_key, rsp_data.out_key);
                    check_field("out_flags", want.out_flags, rsp_data.out_flags);
                    check_field("out_velocity", want.out_velocity, rsp_data.out_velocity);
                    check_field("out_mode", want.out_mode, rsp_data.out_mode);
                    check_field("out_track", want.out_track, rsp_data.out_track);
                    check_field("out_capture_ms", want.out_capture_ms,
                                rsp_data.out_capture_ms);
                    check_field("fill_level", want.fill_level, rsp_data.fill_level);
                    check_field("drops_seen", want.drops_seen, rsp_data.drops_seen);
                end
            end
            if (req_valid && req_ready)
                pending_results.push_back(predict_result(req_data));
        end
        awaiting = pending_results.size();
    end

endmodule

[sim/testbench.sv]
// Top of the event ring queue testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module testbench;
    import erq_pkg::*;

    // Number of random action words after the directed opening.
    localparam int RANDOM_ITEMS = 1900;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED,
        BURST_NOISE
    } burst_kind_t;

    logic clk;
    logic rst_n;

    // Percent of cycles in which the sender holds back a word and the receiver stalls.
    int unsigned req_gap_pct;
    int unsigned rsp_stall_pct;
    int unsigned random_sent;

    int unsigned mismatches;
    int unsigned awaiting;
    int unsigned stored_events;
    int unsigned full_refusals;
    int unsigned popped_events;
    int unsigned empty_pops;

    erq_chan_if #(.word_t(req_word_t)) req_ch ();
    erq_chan_if #(.word_t(rsp_word_t)) rsp_ch ();

    event_ring_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    event_queue_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_ch.valid),
        .req_ready     (req_ch.ready),
        .req_data      (req_ch.data),
        .rsp_valid     (rsp_ch.valid),
        .rsp_ready     (rsp_ch.ready),
        .rsp_data      (rsp_ch.data),
        .mismatches    (mismatches),
        .awaiting      (awaiting),
        .stored_events (stored_events),
        .full_refusals (full_refusals),
        .popped_events (popped_events),
        .empty_pops    (empty_pops)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Hard stop. The slowest legal run (every word a pop that finds an event, the
    // sender idle and receiver stalled 61 percent each) stays well under a tenth of this.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // The receiver decides once per falling edge whether it takes a result word in
    // the next cycle, so stalls land on every phase of the block's work.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Random event contents with the given action and gate. Every payload bit is drawn,
    // even for actions that ignore the payload.
    function automatic req_word_t event_word(action_t act, logic gate);
        req_word_t w;
        w.action          = act;
        w.gate_open       = gate;
        w.key_index       = 8'($urandom);
        w.is_pressed      = 1'($urandom);
        w.strike_velocity = 8'($urandom);
        w.timer_stamp     = $urandom;
        w.shift_held      = 1'($urandom);
        w.track_armed     = 1'($urandom);
        w.sensor_mode     = 8'($urandom);
        w.active_track    = 8'($urandom);
        w.capture_time_ms = $urandom;
        return w;
    endfunction

    // Offers one word and returns at the falling edge after it was taken. Called at a
    // falling edge, so valid gets a single assignment per time step: it only drops
    // when the sender chooses to idle, and stays high across back-to-back words.
    task automatic send_action(req_word_t w);
        while ($urandom_range(99) < req_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_plain(action_t act);
        send_action(event_word(act, 1'b1));
    endtask

    // Holds the sender back until the block has answered everything it took.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (awaiting != 0)
            @(negedge clk);
    endtask

    // A run of actions biased toward one behavior. Fill runs can be long enough to reach
    // a full ring and collect refusals; drain runs can empty it and hit the empty status.
    task automatic run_burst(burst_kind_t kind, int unsigned len);
        int unsigned roll;
        action_t     act;
        logic        gate;
        repeat (len)
        begin
            roll = $urandom_range(99);
            case (kind)
                BURST_FILL:
                    act = (roll < 88) ? ACT_SUBMIT : (roll < 97) ? ACT_POP :
                          (roll < 99) ? ACT_DISCARD : ACT_CLEAR;
                BURST_DRAIN:
                    act = (roll < 78) ? ACT_POP : (roll < 97) ? ACT_SUBMIT :
                          (roll < 99) ? ACT_DISCARD : ACT_CLEAR;
                BURST_MIXED:
                    act = (roll < 45) ? ACT_SUBMIT : (roll < 90) ? ACT_POP :
                          (roll < 95) ? ACT_DISCARD : ACT_CLEAR;
                default:
                    act = action_t'(2'($urandom_range(3)));
            endcase
            if (kind == BURST_NOISE)
                gate = 1'($urandom);
            else
                gate = ($urandom_range(99) < 94);
            send_action(event_word(act, gate));
            random_sent++;
        end
    endtask

    initial
    begin
        req_word_t   w;
        int unsigned roll;
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        req_gap_pct   = 10;
        rsp_stall_pct = 61;
        random_sent   = 0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening. A pop on the empty queue right after reset, then a refused
        // submit carrying all-ones data, which must leave the serial untouched.
        send_plain(ACT_POP);
        w = '1;
        w.action    = ACT_SUBMIT;
        w.gate_open = 1'b0;
        send_action(w);

        // Extremes of every payload field: all ones, all zeros, then a random event.
        w = '1;
        w.action = ACT_SUBMIT;
        send_action(w);
        w = '0;
        w.action    = ACT_SUBMIT;
        w.gate_open = 1'b1;
        send_action(w);
        send_plain(ACT_SUBMIT);

        // Three pops return the events in order, the fourth finds the queue empty.
        repeat (4)
            send_plain(ACT_POP);

        // A discard drops pending events but keeps the serial count running.
        send_plain(ACT_SUBMIT);
        send_plain(ACT_SUBMIT);
        send_plain(ACT_DISCARD);
        send_plain(ACT_POP);
        send_plain(ACT_SUBMIT);

        // A clear restarts the serials at one; the old entry must not come back.
        send_plain(ACT_CLEAR);
        send_plain(ACT_POP);
        send_plain(ACT_SUBMIT);
        send_plain(ACT_POP);

        // Discard and clear on an already empty queue.
        send_plain(ACT_DISCARD);
        send_plain(ACT_CLEAR);

        // Random part in three stretches with different flow control. Between them the
        // sender waits until every result is back, so the block also runs dry.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    req_gap_pct   = 10;
                    rsp_stall_pct = 61;
                end
                1:
                begin
                    req_gap_pct   = 61;
                    rsp_stall_pct = 10;
                end
                default:
                begin
                    req_gap_pct   = 0;
                    rsp_stall_pct = 0;
                end
            endcase
            while (random_sent < (phase + 1) * RANDOM_ITEMS / 3)
            begin
                roll = $urandom_range(9);
                if (roll < 4)
                    run_burst(BURST_FILL, $urandom_range(40, 90));
                else if (roll < 7)
                    run_burst(BURST_DRAIN, $urandom_range(10, 70));
                else if (roll < 9)
                    run_burst(BURST_MIXED, $urandom_range(10, 40));
                else
                    run_burst(BURST_NOISE, $urandom_range(5, 15));
            end
            drain_results();
        end

        // Let any stray result word show up before the verdict.
        repeat (10)
            @(negedge clk);

        $display("Covered %0d random actions after the directed set: %0d events stored,",
                 random_sent, stored_events);
        $display("%0d returned by pops, %0d pops on an empty queue, %0d refused as full.",
                 popped_events, empty_pops, full_refusals);
        if (mismatches == 0 && awaiting == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/erq_pkg.sv
sv/erq_chan_if.sv
sv/erq_ram.sv
sv/erq_ptr.sv
sv/event_ring_queue_top.sv
sim/event_queue_checker.sv
sim/testbench.sv
